@@ rtl/core/e2r_pkg.sv @@
// Shared constants, types and arithmetic helpers for the Euler angle to matrix pipeline.
`default_nettype none
package e2r_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_W      = FRAC_BITS + 2;
   localparam int SUM_W      = OUT_W + 1;
   localparam int PROD_W     = 2 * OUT_W;
   localparam int ORDER_W    = 5;

   localparam int Q_BITS     = 30;
   localparam int R_W        = ANGLE_BITS - 2;
   localparam int PI_W       = 32;
   localparam logic [PI_W-1:0] PI_Q30 = 32'd3373259426;
   localparam int XP_W       = R_W + PI_W;
   localparam int X_W        = 31;
   localparam int X2_W       = 32;
   localparam int TERM_W     = 32;
   localparam int V_W        = 34;
   localparam int RCP_W      = 34;
   localparam int DIV_W      = 9;
   localparam int ACC_W      = 34;

   localparam int NCELL      = 9;
   localparam int CELL_LAT   = 3;
   localparam int SC_LAT     = 3 + NCELL * CELL_LAT + 1;
   localparam int MAT_LAT    = 3;
   localparam int PIPE_LAT   = SC_LAT + MAT_LAT;

   localparam logic [63:0] TWO_V = 64'd1 << V_W;
   localparam logic [63:0] Q_RND = 64'd1 << (Q_BITS - 1);
   localparam logic signed [ACC_W-1:0] ONE_Q = ACC_W'(64'd1 << Q_BITS);
   localparam logic signed [OUT_W-1:0] ONE_FX = OUT_W'(64'd1 << FRAC_BITS);

   // order word fields
   localparam int ORD_PARITY = 2;
   localparam int ORD_REPEAT = 3;
   localparam int ORD_FRAME  = 4;
   localparam logic [1:0] AXIS_BAD = 2'd3;

   typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quad_type;

   typedef struct packed {
      logic [X2_W-1:0]          x2;
      logic [TERM_W-1:0]        st;
      logic [TERM_W-1:0]        ct;
      logic signed [ACC_W-1:0]  ssum;
      logic signed [ACC_W-1:0]  csum;
      quad_type                 quad;
   } taylor_type;

   typedef struct packed {
      logic [DIV_W-1:0] ds;
      logic [DIV_W-1:0] dc;
      logic [RCP_W-1:0] ms;
      logic [RCP_W-1:0] mc;
      logic             odd;
   } cell_const_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] cc;
      logic signed [OUT_W-1:0] csh;
      logic signed [OUT_W-1:0] sc;
      logic signed [OUT_W-1:0] ss;
      logic signed [OUT_W-1:0] psi;
      logic signed [OUT_W-1:0] pci;
      logic signed [OUT_W-1:0] psh;
      logic signed [OUT_W-1:0] pch;
      logic signed [OUT_W-1:0] sj;
      logic signed [OUT_W-1:0] cj;
   } mat1_type;

   typedef struct packed {
      mat1_type                p;
      logic signed [OUT_W-1:0] qss;
      logic signed [OUT_W-1:0] qcsh;
      logic signed [OUT_W-1:0] qsc;
      logic signed [OUT_W-1:0] qcc;
   } mat2_type;

   // Taylor divisors (2k)(2k+1) for sine, (2k-1)(2k) for cosine, k = 1..9
   localparam logic [DIV_W-1:0] DIV_S [NCELL] = '{
      9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342};
   localparam logic [DIV_W-1:0] DIV_C [NCELL] = '{
      9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306};
   localparam logic [RCP_W-1:0] RCP_S [NCELL] = '{
      RCP_W'(TWO_V / 6),   RCP_W'(TWO_V / 20),  RCP_W'(TWO_V / 42),
      RCP_W'(TWO_V / 72),  RCP_W'(TWO_V / 110), RCP_W'(TWO_V / 156),
      RCP_W'(TWO_V / 210), RCP_W'(TWO_V / 272), RCP_W'(TWO_V / 342)};
   localparam logic [RCP_W-1:0] RCP_C [NCELL] = '{
      RCP_W'(TWO_V / 2),   RCP_W'(TWO_V / 12),  RCP_W'(TWO_V / 30),
      RCP_W'(TWO_V / 56),  RCP_W'(TWO_V / 90),  RCP_W'(TWO_V / 132),
      RCP_W'(TWO_V / 182), RCP_W'(TWO_V / 240), RCP_W'(TWO_V / 306)};

   function automatic cell_const_type cell_const(input int idx);
      cell_const_type c;
      c.ds  = DIV_S[idx];
      c.dc  = DIV_C[idx];
      c.ms  = RCP_S[idx];
      c.mc  = RCP_C[idx];
      c.odd = ((idx & 1) == 0);
      return c;
   endfunction

   // product of two fixed-point values, rounded half away from zero
   function automatic logic signed [OUT_W-1:0] fx_mul(input logic signed [OUT_W-1:0] a,
                                                      input logic signed [OUT_W-1:0] b);
      logic signed [PROD_W-1:0] p;
      logic [PROD_W-1:0]        mag;
      logic [PROD_W-1:0]        rnd;
      p   = PROD_W'(a) * PROD_W'(b);
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      rnd = (mag + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return p[PROD_W-1] ? OUT_W'(-OUT_W'(rnd)) : OUT_W'(rnd);
   endfunction

   function automatic logic signed [OUT_W-1:0] fx_sat(input logic signed [SUM_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > SUM_W'(ONE_FX)) r = ONE_FX;
      else if (v < -SUM_W'(ONE_FX)) r = -ONE_FX;
      else r = OUT_W'(v);
      return r;
   endfunction

   function automatic logic [1:0] axis_perm(input logic [2:0] sel, input int idx);
      logic [1:0] a0, a1, a2;
      case (sel)
         3'd0: begin a0 = 2'd0; a1 = 2'd1; a2 = 2'd2; end
         3'd1: begin a0 = 2'd1; a1 = 2'd2; a2 = 2'd0; end
         3'd2: begin a0 = 2'd2; a1 = 2'd0; a2 = 2'd1; end
         3'd3: begin a0 = 2'd0; a1 = 2'd2; a2 = 2'd1; end
         3'd4: begin a0 = 2'd1; a1 = 2'd0; a2 = 2'd2; end
         3'd5: begin a0 = 2'd2; a1 = 2'd1; a2 = 2'd0; end
         default: begin a0 = 2'd0; a1 = 2'd1; a2 = 2'd2; end
      endcase
      return (idx == 0) ? a0 : ((idx == 1) ? a1 : a2);
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/e2r_taylor_cell.sv @@
// One Taylor term of the sine/cosine series: multiply, divide by constant, accumulate.
`default_nettype none
module e2r_taylor_cell import e2r_pkg::*; (
   input  logic           clock,
   input  logic           adv,
   input  cell_const_type cst,
   input  taylor_type     d_in,
   output taylor_type     d_out
);

   logic [63:0]       ps_in, pc_in, ps_ff, pc_ff;
   taylor_type        t1_ff, t2_ff, t3_in, t3_ff;
   logic [V_W-1:0]    vs_in, vc_in, vs_ff, vc_ff;
   logic [2*V_W-1:0]  qs_prod, qc_prod;
   logic [V_W-1:0]    qes_in, qec_in, qes_ff, qec_ff;
   logic [V_W:0]      rs, rc;
   logic [V_W-1:0]    qs, qc;

   assign ps_in = 64'(d_in.st) * 64'(d_in.x2);
   assign pc_in = 64'(d_in.ct) * 64'(d_in.x2);

   // floor(v/d) via reciprocal: estimate is q or q-1
   assign vs_in   = V_W'((ps_ff + Q_RND) >> Q_BITS);
   assign vc_in   = V_W'((pc_ff + Q_RND) >> Q_BITS);
   assign qs_prod = (2*V_W)'(vs_in) * (2*V_W)'(cst.ms);
   assign qc_prod = (2*V_W)'(vc_in) * (2*V_W)'(cst.mc);
   assign qes_in  = qs_prod[2*V_W-1:V_W];
   assign qec_in  = qc_prod[2*V_W-1:V_W];

   always_comb begin
      rs = (V_W+1)'(vs_ff) - (V_W+1)'(qes_ff) * (V_W+1)'(cst.ds);
      rc = (V_W+1)'(vc_ff) - (V_W+1)'(qec_ff) * (V_W+1)'(cst.dc);
      qs = (rs >= (V_W+1)'(cst.ds)) ? qes_ff + V_W'(1) : qes_ff;
      qc = (rc >= (V_W+1)'(cst.dc)) ? qec_ff + V_W'(1) : qec_ff;
      t3_in    = t2_ff;
      t3_in.st = TERM_W'(qs);
      t3_in.ct = TERM_W'(qc);
      if (cst.odd) begin
         t3_in.ssum = t2_ff.ssum - $signed(ACC_W'(qs));
         t3_in.csum = t2_ff.csum - $signed(ACC_W'(qc));
      end else begin
         t3_in.ssum = t2_ff.ssum + $signed(ACC_W'(qs));
         t3_in.csum = t2_ff.csum + $signed(ACC_W'(qc));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ps_ff  <= ps_in;
         pc_ff  <= pc_in;
         t1_ff  <= d_in;
         vs_ff  <= vs_in;
         vc_ff  <= vc_in;
         qes_ff <= qes_in;
         qec_ff <= qec_in;
         t2_ff  <= t1_ff;
         t3_ff  <= t3_in;
      end
   end

   assign d_out = t3_ff;

endmodule
`default_nettype wire

@@ rtl/core/e2r_sincos.sv @@
// Pipelined sine and cosine of one angle: reduction, chain of Taylor cells, quadrant fix-up.
`default_nettype none
module e2r_sincos import e2r_pkg::*; (
   input  logic                    clock,
   input  logic                    adv,
   input  logic [ANGLE_BITS-1:0]   angle,
   output logic signed [OUT_W-1:0] sin_val,
   output logic signed [OUT_W-1:0] cos_val
);

   localparam logic [XP_W-1:0] X_RND = XP_W'(64'd1 << (ANGLE_BITS - 2));
   localparam int              F_SH  = Q_BITS - FRAC_BITS;
   localparam logic [ACC_W-1:0] F_RND = (F_SH > 0) ? ACC_W'(64'd1 << (F_SH - 1)) : '0;

   quad_type          quad1_ff, quad2_ff;
   logic [XP_W-1:0]   pr_in, pr_ff;
   logic [X_W-1:0]    x_in, x_ff;
   logic [2*X_W-1:0]  px_in, px_ff;
   taylor_type        head_in, head_ff;
   taylor_type        link [NCELL+1];
   logic [ACC_W-1:0]  sclamp, cclamp;
   logic signed [OUT_W-1:0] sm, cm, sin_in, cos_in, sin_ff, cos_ff;

   assign pr_in = XP_W'(angle[R_W-1:0]) * XP_W'(PI_Q30);
   assign x_in  = X_W'((pr_ff + X_RND) >> (ANGLE_BITS - 1));
   assign px_in = (2*X_W)'(x_in) * (2*X_W)'(x_in);

   always_comb begin
      head_in.x2   = X2_W'((64'(px_ff) + Q_RND) >> Q_BITS);
      head_in.st   = TERM_W'(x_ff);
      head_in.ct   = TERM_W'(ONE_Q);
      head_in.ssum = $signed(ACC_W'(x_ff));
      head_in.csum = ONE_Q;
      head_in.quad = quad2_ff;
   end

   assign link[0] = head_ff;

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      e2r_taylor_cell u_cell (
         .clock (clock),
         .adv   (adv),
         .cst   (cell_const(g)),
         .d_in  (link[g]),
         .d_out (link[g+1])
      );
   end

   always_comb begin
      if (link[NCELL].ssum < 0) sclamp = '0;
      else if (link[NCELL].ssum > ONE_Q) sclamp = ONE_Q;
      else sclamp = link[NCELL].ssum;
      if (link[NCELL].csum < 0) cclamp = '0;
      else if (link[NCELL].csum > ONE_Q) cclamp = ONE_Q;
      else cclamp = link[NCELL].csum;
      sm = OUT_W'((sclamp + F_RND) >> F_SH);
      cm = OUT_W'((cclamp + F_RND) >> F_SH);
      case (link[NCELL].quad)
         QUAD_0:   begin sin_in = sm;  cos_in = cm;  end
         QUAD_90:  begin sin_in = cm;  cos_in = -sm; end
         QUAD_180: begin sin_in = -sm; cos_in = -cm; end
         default:  begin sin_in = -cm; cos_in = sm;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quad1_ff <= quad_type'(angle[ANGLE_BITS-1:ANGLE_BITS-2]);
         pr_ff    <= pr_in;
         quad2_ff <= quad1_ff;
         x_ff     <= x_in;
         px_ff    <= px_in;
         head_ff  <= head_in;
         sin_ff   <= sin_in;
         cos_ff   <= cos_in;
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule
`default_nettype wire

@@ rtl/core/euler_to_rotation_matrix.sv @@
// Euler angles to rotation matrix: top level with angle selection, matrix stages and control.
// Usage:
//   req_ channel carries three angles (fractions of a turn) and a 5-bit order word;
//   rsp_ channel returns the nine Q1.16 matrix entries and an invalid-order flag.
//   Both channels are valid/ready; a word moves when valid and ready are high together.
//   From request accept to response valid a word passes the sine/cosine pipes (three
//   stages of angle reduction, nine Taylor cells of three stages, one of quadrant fix-up),
//   then the first products, the second products, and the sums with the output register.
//   Throughput is one word per cycle; the whole pipeline moves as one, so its rate is
//   set by the response side taking words.
//   When the receiver stalls a held response, the pipeline freezes and req_ready drops
//   until that word is taken; no word is lost or duplicated.
//   Reset clears all valid flags; no word is in flight after reset and data registers
//   need no clearing.
//   An order whose first-axis field is 3 returns a zero matrix with order_invalid set.
`default_nettype none
module euler_to_rotation_matrix import e2r_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ANGLE_BITS-1:0]   req_rot_x,
   input  logic [ANGLE_BITS-1:0]   req_rot_y,
   input  logic [ANGLE_BITS-1:0]   req_rot_z,
   input  logic [ORDER_W-1:0]      req_order,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_m00,
   output logic signed [OUT_W-1:0] rsp_m01,
   output logic signed [OUT_W-1:0] rsp_m02,
   output logic signed [OUT_W-1:0] rsp_m10,
   output logic signed [OUT_W-1:0] rsp_m11,
   output logic signed [OUT_W-1:0] rsp_m12,
   output logic signed [OUT_W-1:0] rsp_m20,
   output logic signed [OUT_W-1:0] rsp_m21,
   output logic signed [OUT_W-1:0] rsp_m22,
   output logic                    rsp_order_invalid
);

   logic                    adv;
   logic [PIPE_LAT-1:0]     vld_in, vld_ff;
   logic [ORDER_W-1:0]      ord_ff [PIPE_LAT-1];
   logic [ANGLE_BITS-1:0]   ti, tj, th, ti_in, tj_in, th_in;
   logic signed [OUT_W-1:0] si, ci, sj, cj, sh, ch;
   logic [ORDER_W-1:0]      o1, o2, o3;
   logic signed [OUT_W-1:0] b1, a2;
   mat1_type                m1_in, m1_ff;
   mat2_type                m2_in, m2_ff;
   logic signed [OUT_W-1:0] e  [3][3];
   logic signed [OUT_W-1:0] mo [3][3];
   logic signed [OUT_W-1:0] mo_in [3][3];
   logic signed [OUT_W-1:0] mo_ff [3][3];
   logic                    inv_in, inv_ff;
   logic [2:0]              sel;

   assign adv       = !vld_ff[PIPE_LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[PIPE_LAT-2:0], req_valid};

   // rotating frame swaps first and third angle, odd parity negates all three
   always_comb begin
      if (req_order[ORD_FRAME]) begin
         ti = req_rot_z; tj = req_rot_y; th = req_rot_x;
      end else begin
         ti = req_rot_x; tj = req_rot_y; th = req_rot_z;
      end
      if (req_order[ORD_PARITY]) begin
         ti_in = ANGLE_BITS'(-ti);
         tj_in = ANGLE_BITS'(-tj);
         th_in = ANGLE_BITS'(-th);
      end else begin
         ti_in = ti; tj_in = tj; th_in = th;
      end
   end

   e2r_sincos u_sc_i (.clock(clock), .adv(adv), .angle(ti_in), .sin_val(si), .cos_val(ci));
   e2r_sincos u_sc_j (.clock(clock), .adv(adv), .angle(tj_in), .sin_val(sj), .cos_val(cj));
   e2r_sincos u_sc_h (.clock(clock), .adv(adv), .angle(th_in), .sin_val(sh), .cos_val(ch));

   assign o1 = ord_ff[SC_LAT-1];
   assign o2 = ord_ff[SC_LAT];
   assign o3 = ord_ff[SC_LAT+1];

   // first products
   assign b1 = o1[ORD_REPEAT] ? sj : cj;
   always_comb begin
      m1_in.cc  = fx_mul(ci, ch);
      m1_in.csh = fx_mul(ci, sh);
      m1_in.sc  = fx_mul(si, ch);
      m1_in.ss  = fx_mul(si, sh);
      m1_in.psi = fx_mul(b1, si);
      m1_in.pci = fx_mul(b1, ci);
      m1_in.psh = fx_mul(b1, sh);
      m1_in.pch = fx_mul(b1, ch);
      m1_in.sj  = sj;
      m1_in.cj  = cj;
   end

   // second products against the middle angle
   assign a2 = o2[ORD_REPEAT] ? m1_ff.cj : m1_ff.sj;
   always_comb begin
      m2_in.p    = m1_ff;
      m2_in.qss  = fx_mul(a2, m1_ff.ss);
      m2_in.qcsh = fx_mul(a2, m1_ff.csh);
      m2_in.qsc  = fx_mul(a2, m1_ff.sc);
      m2_in.qcc  = fx_mul(a2, m1_ff.cc);
   end

   // sums, then scatter through the axis permutation
   always_comb begin
      if (o3[ORD_REPEAT]) begin
         e[0][0] = m2_ff.p.cj;
         e[1][0] = m2_ff.p.psi;
         e[2][0] = m2_ff.p.pci;
         e[0][1] = m2_ff.p.psh;
         e[1][1] = fx_sat(SUM_W'(m2_ff.p.cc) - SUM_W'(m2_ff.qss));
         e[2][1] = fx_sat(-SUM_W'(m2_ff.qcsh) - SUM_W'(m2_ff.p.sc));
         e[0][2] = fx_sat(-SUM_W'(m2_ff.p.pch));
         e[1][2] = fx_sat(SUM_W'(m2_ff.qsc) + SUM_W'(m2_ff.p.csh));
         e[2][2] = fx_sat(SUM_W'(m2_ff.qcc) - SUM_W'(m2_ff.p.ss));
      end else begin
         e[0][0] = m2_ff.p.pch;
         e[1][0] = fx_sat(SUM_W'(m2_ff.qsc) - SUM_W'(m2_ff.p.csh));
         e[2][0] = fx_sat(SUM_W'(m2_ff.qcc) + SUM_W'(m2_ff.p.ss));
         e[0][1] = m2_ff.p.psh;
         e[1][1] = fx_sat(SUM_W'(m2_ff.qss) + SUM_W'(m2_ff.p.cc));
         e[2][1] = fx_sat(SUM_W'(m2_ff.qcsh) - SUM_W'(m2_ff.p.sc));
         e[0][2] = fx_sat(-SUM_W'(m2_ff.p.sj));
         e[1][2] = m2_ff.p.psi;
         e[2][2] = m2_ff.p.pci;
      end
      sel    = o3[ORD_PARITY] ? 3'(o3[1:0]) + 3'd3 : 3'(o3[1:0]);
      inv_in = (o3[1:0] == AXIS_BAD);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mo[r][c] = '0;
         end
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mo[axis_perm(sel, r)][axis_perm(sel, c)] = e[r][c];
         end
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mo_in[r][c] = inv_in ? '0 : mo[r][c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ord_ff[0] <= req_order;
         for (int i = 1; i < PIPE_LAT-1; i++) begin
            ord_ff[i] <= ord_ff[i-1];
         end
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         mo_ff  <= mo_in;
         inv_ff <= inv_in;
      end
   end

   assign rsp_valid         = vld_ff[PIPE_LAT-1];
   assign rsp_m00           = mo_ff[0][0];
   assign rsp_m01           = mo_ff[0][1];
   assign rsp_m02           = mo_ff[0][2];
   assign rsp_m10           = mo_ff[1][0];
   assign rsp_m11           = mo_ff[1][1];
   assign rsp_m12           = mo_ff[1][2];
   assign rsp_m20           = mo_ff[2][0];
   assign rsp_m21           = mo_ff[2][1];
   assign rsp_m22           = mo_ff[2][2];
   assign rsp_order_invalid = inv_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_order_invalid |-> rsp_m00 == 0 && rsp_m11 == 0 && rsp_m22 == 0
                                       && rsp_m01 == 0 && rsp_m12 == 0 && rsp_m20 == 0)
      else $error("invalid order word with nonzero matrix");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_diag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_m00 <= ONE_FX && rsp_m00 >= -ONE_FX
                    && rsp_m11 <= ONE_FX && rsp_m11 >= -ONE_FX
                    && rsp_m22 <= ONE_FX && rsp_m22 >= -ONE_FX)
      else $error("matrix entry outside unit range");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench for the Euler angle to rotation matrix block: queued driver, monitor and predictor.
`timescale 1ns / 1ps
module tb_top;
   import e2r_pkg::*;

   typedef struct {
      logic [15:0] rx, ry, rz;
      logic [4:0]  ord;
   } angle_word_type;

   typedef struct {
      logic signed [17:0] m [9];
      logic               bad;
   } matrix_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_rot_x = '0, req_rot_y = '0, req_rot_z = '0;
   logic [4:0]  req_order = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [17:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                       rsp_m20, rsp_m21, rsp_m22;
   logic rsp_order_invalid;

   euler_to_rotation_matrix DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   angle_word_type  pending_words[$];
   matrix_word_type expected_matrices[$];
   int n_errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off = 1'b0;
   bit in_taken = 1'b0;
   int quiet_cycles = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      n_errors++;
   endtask

   function automatic longint round_shift(input longint unsigned v, input int s);
      return longint'((v + (64'd1 << (s - 1))) >> s);
   endfunction

   function automatic longint mul_q16(input longint a, input longint b);
      longint unsigned ua, ub, p;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = (ua * ub + 64'd32768) >> 16;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint clip_one(input longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
   endfunction

   function automatic longint clip_q30(input longint v);
      if (v < 0) return 0;
      if (v > (64'd1 << 30)) return 64'd1 << 30;
      return v;
   endfunction

   // Taylor series on the quadrant remainder, then quadrant fix-up
   task automatic sin_cos(input logic [15:0] a, output longint sn, output longint cs);
      longint unsigned x, x2, st, ct;
      longint ssum, csum, sm, cm;
      x = round_shift(longint'(a[13:0]) * 64'd3373259426, 15);
      x2 = round_shift(x * x, 30);
      ssum = x; csum = 64'd1 << 30;
      st = x; ct = 64'd1 << 30;
      for (int k = 1; k < 10; k++) begin
         st = round_shift(st * x2, 30) / ((2 * k) * (2 * k + 1));
         ct = round_shift(ct * x2, 30) / ((2 * k - 1) * (2 * k));
         if (k & 1) begin
            ssum -= st; csum -= ct;
         end else begin
            ssum += st; csum += ct;
         end
      end
      sm = round_shift(clip_q30(ssum), 14);
      cm = round_shift(clip_q30(csum), 14);
      case (a[15:14])
         2'd0: begin sn = sm; cs = cm; end
         2'd1: begin sn = cm; cs = -sm; end
         2'd2: begin sn = -sm; cs = -cm; end
         default: begin sn = -cm; cs = sm; end
      endcase
   endtask

   task automatic predict_matrix(input angle_word_type w, output matrix_word_type r);
      logic [15:0] ti, tj, th;
      longint si, ci, sj, cj, sh, ch, cc, csh, sc, ss;
      longint m [3][3];
      int a0, a1, a2;
      logic [2:0] sel;
      for (int i = 0; i < 9; i++) r.m[i] = '0;
      r.bad = (w.ord[1:0] == AXIS_BAD);
      if (r.bad) return;
      if (w.ord[ORD_FRAME]) begin
         ti = w.rz; tj = w.ry; th = w.rx;
      end else begin
         ti = w.rx; tj = w.ry; th = w.rz;
      end
      if (w.ord[ORD_PARITY]) begin
         ti = -ti; tj = -tj; th = -th;
      end
      sin_cos(ti, si, ci);
      sin_cos(tj, sj, cj);
      sin_cos(th, sh, ch);
      cc = mul_q16(ci, ch); csh = mul_q16(ci, sh);
      sc = mul_q16(si, ch); ss = mul_q16(si, sh);
      sel = w.ord[ORD_PARITY] ? 3'(w.ord[1:0]) + 3'd3 : 3'(w.ord[1:0]);
      case (sel)
         3'd0: begin a0 = 0; a1 = 1; a2 = 2; end
         3'd1: begin a0 = 1; a1 = 2; a2 = 0; end
         3'd2: begin a0 = 2; a1 = 0; a2 = 1; end
         3'd3: begin a0 = 0; a1 = 2; a2 = 1; end
         3'd4: begin a0 = 1; a1 = 0; a2 = 2; end
         default: begin a0 = 2; a1 = 1; a2 = 0; end
      endcase
      if (w.ord[ORD_REPEAT]) begin
         m[a0][a0] = cj;
         m[a1][a0] = mul_q16(sj, si);
         m[a2][a0] = mul_q16(sj, ci);
         m[a0][a1] = mul_q16(sj, sh);
         m[a1][a1] = clip_one(cc - mul_q16(cj, ss));
         m[a2][a1] = clip_one(-mul_q16(cj, csh) - sc);
         m[a0][a2] = -mul_q16(sj, ch);
         m[a1][a2] = clip_one(mul_q16(cj, sc) + csh);
         m[a2][a2] = clip_one(mul_q16(cj, cc) - ss);
      end else begin
         m[a0][a0] = mul_q16(cj, ch);
         m[a1][a0] = clip_one(mul_q16(sj, sc) - csh);
         m[a2][a0] = clip_one(mul_q16(sj, cc) + ss);
         m[a0][a1] = mul_q16(cj, sh);
         m[a1][a1] = clip_one(mul_q16(sj, ss) + cc);
         m[a2][a1] = clip_one(mul_q16(sj, csh) - sc);
         m[a0][a2] = -sj;
         m[a1][a2] = mul_q16(cj, si);
         m[a2][a2] = mul_q16(cj, ci);
      end
      for (int i = 0; i < 9; i++) r.m[i] = 18'(clip_one(m[i / 3][i % 3]));
   endtask

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'({2'($urandom_range(0, 3)), 14'h0000} + 16'($urandom_range(0, 2))
                       - 16'd1);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_word(input logic [15:0] x, y, z, input logic [4:0] o);
      angle_word_type w;
      w.rx = x; w.ry = y; w.rz = z; w.ord = o;
      pending_words.push_back(w);
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || in_taken) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               angle_word_type w;
               w = pending_words.pop_front();
               req_valid <= 1'b1;
               req_rot_x <= w.rx; req_rot_y <= w.ry; req_rot_z <= w.rz;
               req_order <= w.ord;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor: sample on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         in_taken <= req_valid && req_ready;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (req_valid && req_ready) begin
            angle_word_type w;
            matrix_word_type r;
            w.rx = req_rot_x; w.ry = req_rot_y; w.rz = req_rot_z; w.ord = req_order;
            predict_matrix(w, r);
            expected_matrices.push_back(r);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_matrices.size() == 0) begin
               report_mismatch("unexpected word", 0, 0);
            end else begin
               matrix_word_type e;
               logic signed [17:0] got [9];
               e = expected_matrices.pop_front();
               got = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                       rsp_m20, rsp_m21, rsp_m22};
               for (int i = 0; i < 9; i++)
                  if (got[i] !== e.m[i])
                     report_mismatch($sformatf("m%0d%0d", i / 3, i % 3), got[i], e.m[i]);
               if (rsp_order_invalid !== e.bad)
                  report_mismatch("order_invalid", rsp_order_invalid, e.bad);
            end
         end
         if (quiet_cycles > 5000) begin
            $display("euler_to_rotation_matrix: mismatch");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_matrices.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int pct_sets [4][2] = '{'{0, 0}, '{61, 0}, '{0, 61}, '{11, 11}};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // directed: every order code, angle extremes, quadrant edges
      for (int o = 0; o < 32; o++) queue_word(16'h0000, 16'hFFFF, 16'h8000, 5'(o));
      queue_word(16'h4000, 16'hC000, 16'h3FFF, 5'd3);
      queue_word(16'h1234, 16'h5678, 16'h9ABC, 5'd31);
      queue_word(16'hFFFF, 16'h0001, 16'h7FFF, 5'd13);
      queue_word(16'hAAAA, 16'h5555, 16'hC001, 5'd21);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = pct_sets[ph][0];
         recv_stall_pct = pct_sets[ph][1];
         for (int i = 0; i < 200; i++)
            queue_word(rand_angle(), rand_angle(), rand_angle(), 5'($urandom));
         if (ph == 0) begin
            // long receiver hold-off so the pipeline fills and req_ready drops
            hold_off = 1'b1;
            repeat (120) @(posedge clock);
            hold_off = 1'b0;
         end
         drain();
      end
      repeat (50) @(posedge clock);
      if (n_errors == 0)
         $display("euler_to_rotation_matrix: match");
      else
         $display("euler_to_rotation_matrix: mismatch");
      $finish;
   end
endmodule
